### hw/rtl/dse_pkg.sv
// Shared types and constants of the descriptive statistics engine.
// No dependencies; imported by the top level.
package dse_pkg;

  // Fixed-point formats of the results
  localparam int unsigned RECIP_FRAC = 32;  // fraction bits of one reciprocal
  localparam int unsigned AVG_FRAC   = 8;   // fraction bits of the mean
  localparam int unsigned HM_SHIFT   = 40;  // count scaling for the harmonic mean
  localparam int unsigned DEV_FRAC   = 16;  // scaling of the variance (8 bits after root)
  localparam int unsigned RES_W      = 24;  // width of mean, harmonic mean, deviation
  localparam int unsigned STATUS_W   = 2;

  localparam int unsigned STAT_SINGLE = 0;  // status bit: one sample only
  localparam int unsigned STAT_ZERO   = 1;  // status bit: a zero sample seen

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_GET,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_STAT_RD,
    ST_STAT_GET,
    ST_STAT_NEXT,
    ST_MUL,
    ST_AVG_GO,
    ST_HM_GO,
    ST_DEV_GO,
    ST_DIV_WAIT,
    ST_SQRT_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_RECIP,
    OP_AVG,
    OP_HM,
    OP_DEV
  } div_op_e;

endpackage

### hw/rtl/dse_ram.sv
// Simple dual-port sample memory: one write and one registered read per cycle.
// No dependencies.
module dse_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dse_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; shared by all divisions of the engine.
module dse_div #(
  parameter int unsigned DVD_W = 68,
  parameter int unsigned DVS_W = 43
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hw/rtl/dse_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// No dependencies; RAD_W must be even.
module dse_sqrt #(
  parameter int unsigned RAD_W = 68
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   radicand_i,
  output logic               done_o,
  output logic [RAD_W/2-1:0] root_o
);

  localparam int unsigned RT_W  = RAD_W / 2;
  localparam int unsigned REM_W = RT_W + 2;
  localparam int unsigned CNT_W = $clog2(RT_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [RT_W-1:0]  root_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      root_q <= {root_q[RT_W-2:0], ge};
      rem_q  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hw/rtl/descriptive_statistics_engine.sv
// Descriptive statistics engine, top level: load sequencer, in-memory sort and statistics pass.
// Depends on dse_pkg, dse_ram, dse_div and dse_sqrt.
//
// Usage:
//  - Input stream (s_axis): one unsigned sample per item, tlast marks the final sample of a
//    set. Samples load at one item per cycle into the sample memory; beyond MAX_SAMPLES they
//    are dropped, but a tlast on a dropped item still closes the set.
//  - After tlast, tready stays low while the set is processed:
//      sort      : in-place insertion sort over the memory, each element moving up past the
//                  larger ones before it, through the single read port;
//      stats pass: per sample a read, plus a reciprocal division of each nonzero sample on
//                  the shared serial divider;
//      finish    : CW multiply steps, up to three divisions on the shared divider, and a
//                  square root.
//  - Output stream (m_axis): one item per set with all statistics in tdata and the status
//    flags in tuser, held in an output register. If the receiver stalls, the next set still
//    loads and is processed; the engine waits before writing its result until the register
//    frees up.
//  - Reset clears the sample count, sequencer and output valid; memory contents are not
//    cleared since only entries below the count are ever used.
module descriptive_statistics_engine
  import dse_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: sample
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                    s_axis_tlast_i,
  // tdata: minimum, maximum, spread, most_frequent, middle_value, quartile_gap,
  //        total, average, harmonic_average, deviation
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [((6*SAMPLE_BITS+SAMPLE_BITS+$clog2(MAX_SAMPLES)+3*RES_W+7)/8)*8-1:0]
                                  m_axis_tdata_o,
  // tuser: status (single sample, zero sample)
  output logic [STATUS_W-1:0]     m_axis_tuser_o
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned AW     = $clog2(MAX_SAMPLES);
  localparam int unsigned CW     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned MCW    = $clog2(CW);
  localparam int unsigned TOT_W  = SB + AW;
  localparam int unsigned SQ_W   = 2 * SB + AW;
  localparam int unsigned NUM_W  = 2 * SB + 2 * AW;
  localparam int unsigned RS_W   = RECIP_FRAC + 1 + AW;
  localparam int unsigned D_W    = 2 * CW;
  localparam int unsigned QR_W   = NUM_W + DEV_FRAC;
  localparam int unsigned RT_W   = QR_W / 2;
  localparam int unsigned DV_A   = (RECIP_FRAC + 1 > TOT_W + AVG_FRAC) ?
                                   RECIP_FRAC + 1 : TOT_W + AVG_FRAC;
  localparam int unsigned DV_B   = (CW + HM_SHIFT > QR_W) ? CW + HM_SHIFT : QR_W;
  localparam int unsigned DVD_W  = (DV_A > DV_B) ? DV_A : DV_B;
  localparam int unsigned RAW_W  = 6 * SB + TOT_W + 3 * RES_W;
  localparam int unsigned OUT_W  = ((RAW_W + 7) / 8) * 8;

  // Sequencer and control
  state_e          state_q, state_d;
  div_op_e         div_op_q, div_op_d;
  logic [CW-1:0]   count_q;
  logic            out_valid_q;

  // Working registers
  logic [CW-1:0]   n_q, i_q, k_q;
  logic [AW-1:0]   j_q;
  logic [SB-1:0]   v_q;
  logic [SB-1:0]   min_q, max_q, mid_q, q1v_q, q3v_q;
  logic [SB-1:0]   mode_q, runval_q;
  logic [CW-1:0]   run_q, best_q;
  logic [TOT_W-1:0] total_q;
  logic [SQ_W-1:0] sq_q;
  logic [RS_W-1:0] recip_q;
  logic            zero_q;
  logic [MCW-1:0]  mcnt_q;
  logic [CW-1:0]   nsh_q;
  logic [NUM_W-1:0] nsq_q, tsq_q;
  logic [D_W-1:0]  d_q;
  logic [RES_W-1:0] avg_q, hm_q, dev_q;
  logic [OUT_W-1:0] out_data_q;
  logic [STATUS_W-1:0] out_user_q;

  // Memory and unit interfaces
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [SB-1:0]   mem_wdata, rd_data;
  logic            div_start, div_done;
  logic [DVD_W-1:0] div_dividend, div_quo;
  logic [RS_W-1:0] div_divisor;
  logic            sqrt_start, sqrt_done;
  logic [RT_W-1:0] sqrt_root;

  // Combinational helpers
  logic            in_fire, out_free, store_ok, shift_up, last_k;
  logic [SB-1:0]   sample;
  logic [CW-1:0]   n_next, mid_idx, q1_idx, q3_idx;
  logic [CW:0]     q3_sum;
  logic [2*SB-1:0] sq_term;
  logic [NUM_W-1:0] tsq_term, num;
  logic [D_W-1:0]  d_term;
  logic [RT_W+RES_W-1:0] root_ext;
  logic [RES_W-1:0] quo_sat, root_sat;
  logic [STATUS_W-1:0] status;

  assign sample   = s_axis_tdata_i[SB-1:0];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign store_ok = count_q != CW'(MAX_SAMPLES);
  assign n_next   = store_ok ? count_q + CW'(1) : count_q;
  assign shift_up = rd_data > v_q;
  assign last_k   = (k_q + CW'(1)) == n_q;

  // Median and quartile positions; the upper quartile is clamped to the last element
  assign mid_idx = n_q >> 1;
  assign q1_idx  = mid_idx >> 1;
  assign q3_sum  = (CW + 1)'(mid_idx)
                 + (((CW + 1)'(n_q) - (CW + 1)'(mid_idx) + (CW + 1)'(1)) >> 1);
  assign q3_idx  = (q3_sum > (CW + 1)'(n_q - CW'(1))) ? n_q - CW'(1) : q3_sum[CW-1:0];

  assign sq_term  = (2 * SB)'(rd_data) * (2 * SB)'(rd_data);
  assign tsq_term = NUM_W'(total_q) * NUM_W'(total_q);
  assign d_term   = D_W'(n_q) * D_W'(n_q - CW'(1));
  assign num      = nsq_q - tsq_q;

  assign quo_sat  = (|div_quo[DVD_W-1:RES_W]) ? '1 : div_quo[RES_W-1:0];
  assign root_ext = (RT_W + RES_W)'(sqrt_root);
  assign root_sat = (|root_ext[RT_W+RES_W-1:RES_W]) ? '1 : root_ext[RES_W-1:0];

  assign status[STAT_SINGLE] = n_q == CW'(1);
  assign status[STAT_ZERO]   = zero_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:      if (in_fire && s_axis_tlast_i) state_d = ST_SORT_RD;
      ST_SORT_RD:   state_d = (i_q == n_q) ? ST_STAT_RD : ST_SORT_GET;
      ST_SORT_GET:  state_d = ST_SORT_CMP;
      ST_SORT_CMP:  if (!(shift_up && j_q != AW'(1))) state_d = ST_SORT_PUT;
      ST_SORT_PUT:  state_d = ST_SORT_RD;
      ST_STAT_RD:   state_d = ST_STAT_GET;
      ST_STAT_GET:  state_d = (rd_data != '0) ? ST_DIV_WAIT : ST_STAT_NEXT;
      ST_STAT_NEXT: state_d = last_k ? ST_MUL : ST_STAT_RD;
      ST_MUL:       if (mcnt_q == MCW'(CW - 1)) state_d = ST_AVG_GO;
      ST_AVG_GO:    state_d = ST_DIV_WAIT;
      ST_HM_GO:     state_d = zero_q ? ST_DEV_GO : ST_DIV_WAIT;
      ST_DEV_GO:    state_d = (n_q == CW'(1)) ? ST_DONE : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (div_op_q)
            OP_RECIP: state_d = ST_STAT_NEXT;
            OP_AVG:   state_d = ST_HM_GO;
            OP_HM:    state_d = ST_DEV_GO;
            OP_DEV:   state_d = ST_SQRT_WAIT;
            default:  state_d = ST_LOAD;
          endcase
        end
      end
      ST_SQRT_WAIT: if (sqrt_done) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_LOAD;
      default:      state_d = ST_LOAD;
    endcase
  end

  // Memory ports and unit starts
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = j_q;
    mem_wdata    = v_q;
    mem_raddr    = '0;
    div_start    = 1'b0;
    div_op_d     = div_op_q;
    div_dividend = '0;
    div_divisor  = '0;
    sqrt_start   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        mem_we    = in_fire && store_ok;
        mem_waddr = count_q[AW-1:0];
        mem_wdata = sample;
      end
      ST_SORT_RD:  mem_raddr = i_q[AW-1:0];
      ST_SORT_GET: mem_raddr = i_q[AW-1:0] - AW'(1);
      ST_SORT_CMP: begin
        // shift the larger element up one place, fetch the next one down
        mem_we    = shift_up;
        mem_wdata = rd_data;
        mem_raddr = j_q - AW'(2);
      end
      ST_SORT_PUT: mem_we = 1'b1;
      ST_STAT_RD:  mem_raddr = k_q[AW-1:0];
      ST_STAT_GET: begin
        div_start    = rd_data != '0;
        div_op_d     = OP_RECIP;
        div_dividend = DVD_W'(1) << RECIP_FRAC;
        div_divisor  = RS_W'(rd_data);
      end
      ST_AVG_GO: begin
        div_start    = 1'b1;
        div_op_d     = OP_AVG;
        div_dividend = DVD_W'(total_q) << AVG_FRAC;
        div_divisor  = RS_W'(n_q);
      end
      ST_HM_GO: begin
        div_start    = !zero_q;
        div_op_d     = OP_HM;
        div_dividend = DVD_W'(n_q) << HM_SHIFT;
        div_divisor  = recip_q;
      end
      ST_DEV_GO: begin
        div_start    = n_q != CW'(1);
        div_op_d     = OP_DEV;
        div_dividend = DVD_W'(num) << DEV_FRAC;
        div_divisor  = RS_W'(d_q);
      end
      ST_DIV_WAIT: sqrt_start = div_done && (div_op_q == OP_DEV);
      default: ;
    endcase
  end

  assign s_axis_tready_o = state_q == ST_LOAD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      div_op_q    <= OP_RECIP;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_op_q <= div_op_d;
      if (in_fire) begin
        if (s_axis_tlast_i) count_q <= '0;
        else if (store_ok) count_q <= count_q + CW'(1);
      end
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        if (in_fire && s_axis_tlast_i) begin
          n_q <= n_next;
          i_q <= CW'(1);
        end
      end
      ST_SORT_RD: begin
        if (i_q == n_q) begin
          k_q     <= '0;
          total_q <= '0;
          sq_q    <= '0;
          recip_q <= '0;
          zero_q  <= 1'b0;
        end
      end
      ST_SORT_GET: begin
        v_q <= rd_data;
        j_q <= i_q[AW-1:0];
      end
      ST_SORT_CMP: if (shift_up) j_q <= j_q - AW'(1);
      ST_SORT_PUT: i_q <= i_q + CW'(1);
      ST_STAT_GET: begin
        total_q <= total_q + TOT_W'(rd_data);
        sq_q    <= sq_q + SQ_W'(sq_term);
        if (rd_data == '0) zero_q <= 1'b1;
        if (k_q == '0) min_q <= rd_data;
        if (last_k) max_q <= rd_data;
        if (k_q == mid_idx) mid_q <= rd_data;
        if (k_q == q1_idx) q1v_q <= rd_data;
        if (k_q == q3_idx) q3v_q <= rd_data;
        // longest run of equal values, first (smallest) wins a tie
        if (k_q == '0) begin
          runval_q <= rd_data;
          run_q    <= CW'(1);
          best_q   <= '0;
          mode_q   <= rd_data;
        end else if (rd_data == runval_q) begin
          run_q <= run_q + CW'(1);
        end else begin
          if (run_q > best_q) begin
            best_q <= run_q;
            mode_q <= runval_q;
          end
          runval_q <= rd_data;
          run_q    <= CW'(1);
        end
      end
      ST_STAT_NEXT: begin
        k_q <= k_q + CW'(1);
        if (last_k) begin
          // the final run competes too
          if (run_q > best_q) mode_q <= runval_q;
          mcnt_q <= '0;
          nsq_q  <= '0;
          nsh_q  <= n_q;
        end
      end
      ST_MUL: begin
        // n * sum of squares, shift-add from the top bit of n
        nsq_q  <= {nsq_q[NUM_W-2:0], 1'b0} + (nsh_q[CW-1] ? NUM_W'(sq_q) : '0);
        nsh_q  <= {nsh_q[CW-2:0], 1'b0};
        mcnt_q <= mcnt_q + MCW'(1);
        tsq_q  <= tsq_term;
        d_q    <= d_term;
      end
      ST_HM_GO:  if (zero_q) hm_q <= '0;
      ST_DEV_GO: if (n_q == CW'(1)) dev_q <= '0;
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (div_op_q)
            OP_RECIP: recip_q <= recip_q + div_quo[RS_W-1:0];
            OP_AVG:   avg_q   <= quo_sat;
            OP_HM:    hm_q    <= quo_sat;
            default: ;
          endcase
        end
      end
      ST_SQRT_WAIT: if (sqrt_done) dev_q <= root_sat;
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= OUT_W'({dev_q, hm_q, avg_q, total_q, q3v_q - q1v_q, mid_q,
                                mode_q, max_q - min_q, max_q, min_q});
          out_user_q <= status;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  dse_ram #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (SB)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  dse_div #(
    .DVD_W (DVD_W),
    .DVS_W (RS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  dse_sqrt #(
    .RAD_W (QR_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quo[QR_W-1:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SAMPLES))
    else $error("sample count past capacity");

  a_sort_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SORT_CMP |-> (j_q != '0) && (CW'(j_q) <= i_q))
    else $error("insertion position out of range");

  a_stat_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STAT_RD |-> k_q < n_q)
    else $error("statistics pass reads past the set");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished while not awaited");

  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_SQRT_WAIT)
    else $error("root finished while not awaited");
`endif

endmodule
